### rtl/core/p2gs_pkg.sv
// ----------------------------------------------------------------------------
// p2gs_pkg
// Shared types and codes for the particle-to-grid splat core.
// ----------------------------------------------------------------------------
package p2gs_pkg;

    localparam int ACC_W   = 40;
    localparam int WACC_W  = 32;
    localparam int POS_W   = 16;
    localparam int VEL_W   = 16;
    localparam int CIDX_W  = 6;
    localparam int QCNT_W  = 6;

    typedef enum logic [1:0] {
        CMD_SPLAT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SP_ADDR,
        S_SP_MUL,
        S_SP_WR,
        S_RD_ADDR,
        S_RD_DATA,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_en;
        logic sp_addr;
        logic sp_mul;
        logic sp_wr;
        logic rd_addr;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic corner_last;
        logic div_last;
        logic out_busy;
    } t_dp_stat;

endpackage

### rtl/core/p2gs_ctrl.sv
// ----------------------------------------------------------------------------
// p2gs_ctrl
// Sequencer: walks each item through clear, splat or read steps.
// ----------------------------------------------------------------------------
module p2gs_ctrl
    import p2gs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic [1:0] i_command,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;   // clearing pass after reset
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (t_cmd'(i_command))
                        CMD_SPLAT: n_state = S_SP_ADDR;
                        CMD_READ:  n_state = S_RD_ADDR;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SP_ADDR: begin
                o_cmd.sp_addr = 1'b1;
                n_state = S_SP_MUL;
            end
            S_SP_MUL: begin
                o_cmd.sp_mul = 1'b1;
                n_state = S_SP_WR;
            end
            S_SP_WR: begin
                o_cmd.sp_wr = 1'b1;
                n_state = i_stat.corner_last ? S_IDLE : S_SP_ADDR;
            end
            S_RD_ADDR: begin
                o_cmd.rd_addr = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_clear_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_CLEAR) |=> (r_state == S_CLEAR))
        else $error("clear item did not start clearing pass");

    a_div_follows_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_init |=> (r_state == S_DIV))
        else $error("divider did not start after read data");

    a_load_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("item loaded outside idle");

endmodule

### rtl/core/p2gs_dpath.sv
// ----------------------------------------------------------------------------
// p2gs_dpath
// Accumulator memories, weight and product units, serial divider, output reg.
// ----------------------------------------------------------------------------
module p2gs_dpath
    import p2gs_pkg::*;
#(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [VEL_W-1:0]  i_vel_x,
    input  logic signed [VEL_W-1:0]  i_vel_y,
    input  logic [CIDX_W-1:0]        i_cell_col,
    input  logic [CIDX_W-1:0]        i_cell_row,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [15:0]       o_avg_u,
    output logic signed [15:0]       o_avg_v,
    output logic                     o_has_weight
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CXW   = POS_W + 2 - FRAC_BITS;
    localparam int WW    = FRAC_BITS + 1;
    localparam int PW    = VEL_W + WW + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
    localparam logic [2*WW-1:0] HALF = (2*WW)'(1) << (FRAC_BITS - 1);
    localparam logic signed [31:0] COLS_S = 32'(GRID_COLS);
    localparam logic signed [31:0] ROWS_S = 32'(GRID_ROWS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    // item registers
    logic signed [CXW-1:0]   r_cx, r_cy;
    logic [FRAC_BITS-1:0]    r_fx, r_fy;
    logic signed [VEL_W-1:0] r_vx, r_vy;
    logic [CIDX_W-1:0]       r_ccol, r_crow;
    logic [1:0]              r_k;
    logic [AW-1:0]           r_clr;

    // splat pipeline
    logic [WW-1:0]           r_w;
    logic                    r_in;
    logic [AW-1:0]           r_addr;
    logic signed [PW-1:0]    r_pu, r_pv;

    // memories and read data
    logic [ACC_W-1:0]  r_mem_u [CELLS];
    logic [ACC_W-1:0]  r_mem_v [CELLS];
    logic [WACC_W-1:0] r_mem_w [CELLS];
    logic [ACC_W-1:0]  r_rd_u, r_rd_v;
    logic [WACC_W-1:0] r_rd_w;

    // divider
    logic [ACC_W-1:0]  r_qu, r_qv;
    logic [WACC_W-1:0] r_ru, r_rv, r_den;
    logic              r_su, r_sv, r_zero, r_rin;
    logic [QCNT_W-1:0] r_dcnt;

    // output
    logic              r_o_valid;
    logic signed [15:0] r_avg_u, r_avg_v;
    logic              r_has_w;

    // ---- corner weight and address ----
    logic [WW-1:0]       ax, ay;
    logic [2*WW-1:0]     wprod;
    logic [WW-1:0]       w_c;
    logic signed [CXW-1:0] col_c, row_c;
    logic signed [31:0]  col32, row32, idx32;
    logic                in_c;

    always_comb begin
        ax    = r_k[1] ? WW'(r_fx) : (ONE - WW'(r_fx));
        ay    = r_k[0] ? WW'(r_fy) : (ONE - WW'(r_fy));
        wprod = ax * ay + HALF;
        w_c   = wprod[FRAC_BITS +: WW];
        col_c = r_cx + CXW'(r_k[1]);
        row_c = r_cy + CXW'(r_k[0]);
        col32 = 32'(col_c);
        row32 = 32'(row_c);
        in_c  = (col32 >= 0) && (col32 < COLS_S) && (row32 >= 0) && (row32 < ROWS_S);
        idx32 = row32 * COLS_S + col32;
    end

    // ---- read cell address ----
    logic signed [31:0] rc32, rr32, ridx32;
    logic               rin_c;

    always_comb begin
        rc32   = 32'(r_ccol);
        rr32   = 32'(r_crow);
        rin_c  = (rc32 < COLS_S) && (rr32 < ROWS_S);
        ridx32 = rr32 * COLS_S + rc32;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // floor of the position: arithmetic shift keeps the sign
            r_cx   <= CXW'(i_pos_x >>> FRAC_BITS);
            r_cy   <= CXW'(i_pos_y >>> FRAC_BITS);
            r_fx   <= i_pos_x[FRAC_BITS-1:0];
            r_fy   <= i_pos_y[FRAC_BITS-1:0];
            r_vx   <= i_vel_x;
            r_vy   <= i_vel_y;
            r_ccol <= i_cell_col;
            r_crow <= i_cell_row;
        end
        if (i_cmd.sp_addr) begin
            r_w    <= w_c;
            r_in   <= in_c;
            r_addr <= idx32[AW-1:0];
        end
        if (i_cmd.rd_addr) begin
            r_rin  <= rin_c;
        end
        if (i_cmd.sp_mul) begin
            r_pu <= r_vx * $signed({1'b0, r_w});
            r_pv <= r_vy * $signed({1'b0, r_w});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.load) begin
                r_k <= '0;
            end else if (i_cmd.sp_wr) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.clr_en) begin
                r_clr <= (r_clr == LAST_CELL) ? '0 : r_clr + AW'(1);
            end
        end
    end

    // ---- memories: one write port, one read port ----
    logic              we;
    logic [AW-1:0]     wa, ra;
    logic              re;
    logic [ACC_W-1:0]  wd_u, wd_v;
    logic [WACC_W-1:0] wd_w;

    always_comb begin
        re   = i_cmd.sp_addr || i_cmd.rd_addr;
        ra   = i_cmd.rd_addr ? ridx32[AW-1:0] : idx32[AW-1:0];
        we   = i_cmd.clr_en || (i_cmd.sp_wr && r_in);
        wa   = i_cmd.clr_en ? r_clr : r_addr;
        wd_u = i_cmd.clr_en ? '0 : r_rd_u + ACC_W'(r_pu);
        wd_v = i_cmd.clr_en ? '0 : r_rd_v + ACC_W'(r_pv);
        wd_w = i_cmd.clr_en ? '0 : r_rd_w + WACC_W'(r_w);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_u[wa] <= wd_u;
            r_mem_v[wa] <= wd_v;
            r_mem_w[wa] <= wd_w;
        end
        if (re) begin
            r_rd_u <= r_mem_u[ra];
            r_rd_v <= r_mem_v[ra];
            r_rd_w <= r_mem_w[ra];
        end
    end

    // ---- restoring divider, one quotient bit per cycle for u and v ----
    logic [WACC_W:0] sh_u, sh_v, df_u, df_v;
    logic            ge_u, ge_v;

    always_comb begin
        sh_u = {r_ru, r_qu[ACC_W-1]};
        sh_v = {r_rv, r_qv[ACC_W-1]};
        df_u = sh_u - {1'b0, r_den};
        df_v = sh_v - {1'b0, r_den};
        ge_u = (sh_u >= {1'b0, r_den});
        ge_v = (sh_v >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_su   <= r_rd_u[ACC_W-1];
            r_sv   <= r_rd_v[ACC_W-1];
            r_qu   <= r_rd_u[ACC_W-1] ? (~r_rd_u + ACC_W'(1)) : r_rd_u;
            r_qv   <= r_rd_v[ACC_W-1] ? (~r_rd_v + ACC_W'(1)) : r_rd_v;
            r_ru   <= '0;
            r_rv   <= '0;
            r_den  <= r_rd_w;
            r_zero <= !r_rin || (r_rd_w == '0);
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_qu   <= {r_qu[ACC_W-2:0], ge_u};
            r_qv   <= {r_qv[ACC_W-2:0], ge_v};
            r_ru   <= ge_u ? df_u[WACC_W-1:0] : sh_u[WACC_W-1:0];
            r_rv   <= ge_v ? df_v[WACC_W-1:0] : sh_v[WACC_W-1:0];
            r_dcnt <= r_dcnt + QCNT_W'(1);
        end
    end

    function automatic logic [15:0] sat_q(input logic [ACC_W-1:0] q, input logic neg);
        logic [15:0] res;
        if (neg) begin
            res = (q > ACC_W'(32768)) ? 16'h8000 : (~q[15:0] + 16'd1);
        end else begin
            res = (q > ACC_W'(32767)) ? 16'h7FFF : q[15:0];
        end
        return res;
    endfunction

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg_u <= r_zero ? '0 : $signed(sat_q(r_qu, r_su));
            r_avg_v <= r_zero ? '0 : $signed(sat_q(r_qv, r_sv));
            r_has_w <= !r_zero;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_avg_u      = r_avg_u;
    assign o_avg_v      = r_avg_v;
    assign o_has_weight = r_has_w;

    assign o_stat.clr_last    = (r_clr == LAST_CELL);
    assign o_stat.corner_last = (r_k == 2'd3);
    assign o_stat.div_last    = (r_dcnt == QCNT_W'(ACC_W - 1));
    assign o_stat.out_busy    = r_o_valid;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr_en && i_cmd.sp_wr))
        else $error("clear and splat write in the same cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_o_valid)
        else $error("result loaded over a pending result");

    a_corner_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_k == 2'd0))
        else $error("corner counter not restarted on new item");

endmodule

### rtl/core/particle_to_grid_splat_core.sv
// ----------------------------------------------------------------------------
// particle_to_grid_splat_core
// Bilinear particle-to-grid splat with weight-normalized cell read-back.
// ----------------------------------------------------------------------------
// One item at a time. A splat walks its four corners through the memory
// write and read ports, each corner in the steps address/weight, product
// and read-modify-write. A read runs through the 40-step restoring divider;
// if the previous result is still waiting, the read holds in its output
// state until that result is taken. A clear, and the pass that follows
// reset, sweep the accumulator memories one cell a cycle, during which no
// item is accepted. Command 3 returns straight to idle.
module particle_to_grid_splat_core
    import p2gs_pkg::*;
#(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [VEL_W-1:0]  i_vel_x,
    input  logic signed [VEL_W-1:0]  i_vel_y,
    input  logic [CIDX_W-1:0]        i_cell_col,
    input  logic [CIDX_W-1:0]        i_cell_row,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [15:0]       o_avg_u,
    output logic signed [15:0]       o_avg_v,
    output logic                     o_has_weight
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    p2gs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    p2gs_dpath #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_avg_u      (o_avg_u),
        .o_avg_v      (o_avg_v),
        .o_has_weight (o_has_weight)
    );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for particle_to_grid_splat_core: directed table, then
// random splat/read/clear traffic checked against a bit-accurate grid model.
// ----------------------------------------------------------------------------
module tb
    import p2gs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 64;
    localparam int ROWS = 64;
    localparam int FB   = 8;
    localparam int NCELL = COLS * ROWS;
    localparam longint LIMIT = 3000000;
    localparam int LONG_HOLD = 400;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_ready = 0;
    logic [1:0] i_command = CMD_NOP;
    logic signed [15:0] i_pos_x = 0, i_pos_y = 0, i_vel_x = 0, i_vel_y = 0;
    logic [5:0] i_cell_col = 0, i_cell_row = 0;
    logic o_ready, o_valid, o_has_weight;
    logic signed [15:0] o_avg_u, o_avg_v;

    particle_to_grid_splat_core DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    typedef struct {
        logic [1:0] cmd;
        logic signed [15:0] px, py, vx, vy;
        logic [5:0] col, row;
        bit chk;                       // typed-in expectation present
        logic signed [15:0] eu, ev;
        logic ew;
    } t_row;

    typedef struct {
        logic signed [15:0] u, v;
        logic w;
    } t_cell_avg;

    logic [39:0] grid_u [NCELL];
    logic [39:0] grid_v [NCELL];
    logic [31:0] grid_w [NCELL];
    t_cell_avg pending_avgs[$];
    bit failed = 0;
    longint cycles = 0;
    bit long_stall = 0;
    int hold_cnt = 0;

    function automatic void grid_clear();
        for (int k = 0; k < NCELL; k++) begin
            grid_u[k] = '0; grid_v[k] = '0; grid_w[k] = '0;
        end
    endfunction

    function automatic void grid_splat(logic signed [15:0] px, py, vx, vy);
        longint fx, fy, cx, cy, ax, ay, w, c, r, idx;
        fx = longint'(px) & ((1 << FB) - 1);
        fy = longint'(py) & ((1 << FB) - 1);
        cx = (longint'(px) - fx) >>> FB;
        cy = (longint'(py) - fy) >>> FB;
        for (int dc = 0; dc < 2; dc++)
            for (int dr = 0; dr < 2; dr++) begin
                c = cx + dc; r = cy + dr;
                ax = dc ? fx : (1 << FB) - fx;
                ay = dr ? fy : (1 << FB) - fy;
                w = (ax * ay + (1 << (FB - 1))) >> FB;
                if (c < 0 || c >= COLS || r < 0 || r >= ROWS) continue;
                idx = r * COLS + c;
                grid_u[idx] += 40'(longint'(vx) * w);
                grid_v[idx] += 40'(longint'(vy) * w);
                grid_w[idx] += 32'(w);
            end
    endfunction

    function automatic logic signed [15:0] sat_quot(logic [39:0] acc, logic [31:0] w);
        longint q;
        q = longint'($signed(acc)) / longint'({32'b0, w});
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    function automatic t_cell_avg cell_avg(logic [5:0] col, row);
        t_cell_avg a;
        int idx;
        idx = int'(row) * COLS + int'(col);
        a = '{0, 0, 0};
        if (grid_w[idx] != 0) begin
            a.u = sat_quot(grid_u[idx], grid_w[idx]);
            a.v = sat_quot(grid_v[idx], grid_w[idx]);
            a.w = 1;
        end
        return a;
    endfunction

    // model one accepted item, queue its expectation
    task automatic apply_item(t_row t);
        t_cell_avg a;
        case (t.cmd)
            CMD_SPLAT: grid_splat(t.px, t.py, t.vx, t.vy);
            CMD_CLEAR: grid_clear();
            CMD_READ: begin
                a = cell_avg(t.col, t.row);
                if (t.chk && (a.u !== t.eu || a.v !== t.ev || a.w !== t.ew)) begin
                    $display("%0t table row: expected u=%0d v=%0d w=%0d, model u=%0d v=%0d w=%0d",
                             $time, t.eu, t.ev, t.ew, a.u, a.v, a.w);
                    failed = 1;
                end
                pending_avgs.push_back(a);
            end
            default: ;
        endcase
    endtask

    task automatic send(t_row t);
        i_valid <= 1;
        i_command <= t.cmd;
        i_pos_x <= t.px; i_pos_y <= t.py; i_vel_x <= t.vx; i_vel_y <= t.vy;
        i_cell_col <= t.col; i_cell_row <= t.row;
        do @(posedge i_clk); while (!o_ready);
        apply_item(t);
    endtask

    task automatic gap(int n);
        i_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_row mk(logic [1:0] c, int px, py, vx, vy, int col, row);
        t_row t;
        t = '{c, 16'(px), 16'(py), 16'(vx), 16'(vy), 6'(col), 6'(row), 0, 0, 0, 0};
        return t;
    endfunction

    function automatic t_row mk_read(int col, row, bit chk, int eu, ev, bit ew);
        t_row t;
        t = mk(CMD_READ, 0, 0, 0, 0, col, row);
        t.chk = chk; t.eu = 16'(eu); t.ev = 16'(ev); t.ew = ew;
        return t;
    endfunction

    function automatic t_row rnd_item();
        int k, a;
        k = $urandom_range(99);
        a = $urandom_range(3);
        if (k < 55) begin
            // mostly on-grid positions, some anywhere
            if (a == 0)
                return mk(CMD_SPLAT, $urandom, $urandom, $urandom, $urandom, 0, 0);
            return mk(CMD_SPLAT, $urandom_range(16639) - 256 + (a == 1 ? 0 : 0),
                      $urandom_range(16639) - 256, $urandom, $urandom, 0, 0);
        end
        if (k < 95) return mk_read($urandom_range(63), $urandom_range(63), 0, 0, 0, 0);
        if (k < 97) return mk(CMD_NOP, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
        return mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_cell_avg e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_avgs.size() == 0) begin
                $display("%0t unexpected result u=%0d v=%0d w=%0d", $time,
                         o_avg_u, o_avg_v, o_has_weight);
                failed = 1;
            end else begin
                e = pending_avgs.pop_front();
                if (o_avg_u !== e.u || o_avg_v !== e.v || o_has_weight !== e.w) begin
                    $display("%0t mismatch: expected u=%0d v=%0d w=%0d, got u=%0d v=%0d w=%0d",
                             $time, e.u, e.v, e.w, o_avg_u, o_avg_v, o_has_weight);
                    failed = 1;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (long_stall && hold_cnt < LONG_HOLD) begin
            i_ready <= 0;
            hold_cnt++;
        end else begin
            case ($urandom_range(3))
                0: i_ready <= ($urandom_range(9) < 3);
                default: i_ready <= 1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_row dir[$];
        int burst;
        grid_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        dir.push_back(mk_read(0, 0, 1, 0, 0, 0));
        dir.push_back(mk_read(63, 63, 1, 0, 0, 0));
        // integer position: full weight on one cell
        dir.push_back(mk(CMD_SPLAT, 16'h0500, 16'h0300, 16'h0180, -16'sh0200, 0, 0));
        dir.push_back(mk_read(5, 3, 1, 16'h0180, -16'sh0200, 1));
        dir.push_back(mk_read(6, 3, 1, 0, 0, 0));
        dir.push_back(mk(CMD_SPLAT, 16'h0580, 16'h0380, 16'h7fff, 16'h8000, 0, 0));
        dir.push_back(mk_read(6, 4, 0, 0, 0, 0));
        dir.push_back(mk_read(5, 3, 0, 0, 0, 0));
        // extremes of position: off grid, partial corners
        dir.push_back(mk(CMD_SPLAT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0, 0));
        dir.push_back(mk(CMD_SPLAT, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 0, 0));
        dir.push_back(mk(CMD_SPLAT, 16'hff80, 16'hff80, 16'h1234, 16'hedcb, 0, 0));
        dir.push_back(mk_read(0, 0, 0, 0, 0, 0));
        dir.push_back(mk(CMD_SPLAT, 16'h3f80, 16'h3f80, 16'h4321, 16'hbcde, 0, 0));
        dir.push_back(mk_read(63, 63, 0, 0, 0, 0));
        dir.push_back(mk(CMD_SPLAT, 16'h0001, 16'h00ff, 16'h7fff, 16'h8000, 0, 0));
        dir.push_back(mk_read(0, 1, 0, 0, 0, 0));
        dir.push_back(mk(CMD_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 63, 63));
        dir.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk_read(5, 3, 1, 0, 0, 0));
        dir.push_back(mk_read(0, 0, 1, 0, 0, 0));
        foreach (dir[k]) send(dir[k]);

        // random traffic in bursts
        for (int n = 0; n < 750; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) send(rnd_item());
            if (n > 300 && n < 320) begin
                // sender waits for all pending read results to drain
                gap(1);
                while (pending_avgs.size() != 0) @(posedge i_clk);
            end else if (n > 500 && !long_stall && n < 520) begin
                // receiver holds off for a long stretch while items keep coming
                long_stall = 1;
            end else if ($urandom_range(2) == 0) begin
                gap($urandom_range(1, 20));
            end
        end
        i_valid <= 0;
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
